// ===== hdl/c2c_pkg.sv =====
// ----------------------------------------------------------------------------
// c2c_pkg
// Shared constants, codes and types of the COO to CSR converter.
// ----------------------------------------------------------------------------
`default_nettype none

package c2c_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int MAX_DIM     = 1024;

    localparam int ENTRY_AW = $clog2(MAX_ENTRIES);
    localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
    localparam int PTR_AW   = $clog2(MAX_DIM + 1);
    localparam int DIM_W    = 11;
    localparam int COORD_W  = 10;
    localparam int VAL_W    = 64;
    localparam int REQ_W    = 2;
    localparam int STAT_W   = 3;

    localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL       = 3'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_INDEX  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOT_SORTED = 3'd4;

    localparam logic CFG_NUM_ROWS = 1'b0;
    localparam logic CFG_NUM_COLS = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        OP_LOAD      = 2'd0,
        OP_FINISH    = 2'd1,
        OP_READ_ENT  = 2'd2,
        OP_READ_PTR  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [DIM_W-1:0]   row_number;
        logic [DIM_W-1:0]   col_number;
        logic [VAL_W-1:0]   value_bits;
        logic [DIM_W-1:0]   read_index;
    } item_t;

endpackage

`default_nettype wire

// ===== hdl/c2c_front.sv =====
// ----------------------------------------------------------------------------
// c2c_front
// Accepts request transfers, decodes the request kind and holds them in a
// two-slot queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module c2c_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [c2c_pkg::REQ_W-1:0]     req_type,
    input  wire logic [c2c_pkg::DIM_W-1:0]     row_number,
    input  wire logic [c2c_pkg::DIM_W-1:0]     col_number,
    input  wire logic [c2c_pkg::VAL_W-1:0]     value_bits,
    input  wire logic [c2c_pkg::DIM_W-1:0]     read_index,
    output logic                               item_valid,
    output c2c_pkg::item_t                     item,
    input  wire logic                          item_pop
);
    import c2c_pkg::*;

    item_t       q_mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        push;
    logic        pop;
    item_t       dec;

    always_comb
    begin
        case (req_type)
            OP_LOAD:     dec.op = OP_LOAD;
            OP_FINISH:   dec.op = OP_FINISH;
            OP_READ_ENT: dec.op = OP_READ_ENT;
            default:     dec.op = OP_READ_PTR;
        endcase
        dec.row_number = row_number;
        dec.col_number = col_number;
        dec.value_bits = value_bits;
        dec.read_index = read_index;
    end

    assign in_stall   = (fill_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign item_valid = (fill_reg != 2'd0);
    assign pop        = item_pop && item_valid;
    assign item       = q_mem[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/c2c_back.sv =====
// ----------------------------------------------------------------------------
// c2c_back
// Executes requests: stores triplets, ranks them into the sorted store,
// builds the row pointer table and serves reads through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module c2c_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic                          cfg_index,
    input  wire logic [c2c_pkg::DIM_W-1:0]     cfg_data,
    input  wire logic                          item_valid,
    input  wire c2c_pkg::item_t                item,
    output logic                               item_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [c2c_pkg::STAT_W-1:0]         status,
    output logic [c2c_pkg::COORD_W-1:0]        out_row,
    output logic [c2c_pkg::COORD_W-1:0]        out_col,
    output logic [c2c_pkg::VAL_W-1:0]          out_value,
    output logic [c2c_pkg::DIM_W-1:0]          out_pointer,
    output logic [c2c_pkg::DIM_W-1:0]          entry_total
);
    import c2c_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_RK_ISSUE = 9'b000000010,
        S_RK_KEY   = 9'b000000100,
        S_RK_SCAN  = 9'b000001000,
        S_RK_WRITE = 9'b000010000,
        S_PT_ISSUE = 9'b000100000,
        S_PT_CMP   = 9'b001000000,
        S_RD_ENT   = 9'b010000000,
        S_RD_PTR   = 9'b100000000
    } state_t;

    // load-order store, sorted store, pointer table
    logic [COORD_W-1:0] a_row [MAX_ENTRIES];
    logic [COORD_W-1:0] a_col [MAX_ENTRIES];
    logic [VAL_W-1:0]   a_val [MAX_ENTRIES];
    logic [COORD_W-1:0] b_row [MAX_ENTRIES];
    logic [COORD_W-1:0] b_col [MAX_ENTRIES];
    logic [VAL_W-1:0]   b_val [MAX_ENTRIES];
    logic [CNT_W-1:0]   p_mem [MAX_DIM + 1];

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                sorted_reg, sorted_next;
    logic [DIM_W-1:0]    rows_reg, cols_reg;
    logic [ENTRY_AW-1:0] i_reg, i_next;
    logic [ENTRY_AW-1:0] dj_reg, dj_next;
    logic [ENTRY_AW-1:0] rank_reg, rank_next;
    logic [COORD_W-1:0]  key_row_reg, key_col_reg;
    logic [VAL_W-1:0]    key_val_reg;
    logic                key_load;
    logic [CNT_W-1:0]    pi_reg, pi_next;
    logic [PTR_AW-1:0]   r_reg, r_next;

    logic [ENTRY_AW-1:0] a_addr;
    logic [COORD_W-1:0]  a_rd_row, a_rd_col;
    logic [VAL_W-1:0]    a_rd_val;
    logic                a_we;
    logic [ENTRY_AW-1:0] b_addr;
    logic [COORD_W-1:0]  b_rd_row, b_rd_col;
    logic [VAL_W-1:0]    b_rd_val;
    logic                b_we;
    logic                p_we;
    logic [PTR_AW-1:0]   p_waddr;
    logic [CNT_W-1:0]    p_wdata;
    logic [CNT_W-1:0]    p_rd;

    logic                out_valid_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [COORD_W-1:0]  out_row_reg, out_col_reg;
    logic [VAL_W-1:0]    out_value_reg;
    logic [DIM_W-1:0]    out_pointer_reg;
    logic                out_load;
    logic [STAT_W-1:0]   o_status;
    logic [COORD_W-1:0]  o_row, o_col;
    logic [VAL_W-1:0]    o_value;
    logic [DIM_W-1:0]    o_pointer;
    logic                out_free;
    logic                hit;
    logic                bad_coord;
    logic [DIM_W-1:0]    cfg_eff;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_eff = DIM_W'(1);
        end
        else if (cfg_data > DIM_W'(MAX_DIM))
        begin
            cfg_eff = DIM_W'(MAX_DIM);
        end
        else
        begin
            cfg_eff = cfg_data;
        end
    end

    assign bad_coord = (item.row_number == '0) || (item.row_number > rows_reg)
                    || (item.col_number == '0) || (item.col_number > cols_reg);

    // scanned entry ranks before the key entry: smaller key, or equal key loaded earlier
    assign hit = (a_rd_row < key_row_reg)
              || ((a_rd_row == key_row_reg) && (a_rd_col < key_col_reg))
              || ((a_rd_row == key_row_reg) && (a_rd_col == key_col_reg)
                  && (dj_reg < i_reg));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        sorted_next = sorted_reg;
        i_next      = i_reg;
        dj_next     = dj_reg;
        rank_next   = rank_reg;
        pi_next     = pi_reg;
        r_next      = r_reg;
        key_load    = 1'b0;
        item_pop    = 1'b0;
        a_addr      = i_reg;
        a_we        = 1'b0;
        b_addr      = pi_reg[ENTRY_AW-1:0];
        b_we        = 1'b0;
        p_we        = 1'b0;
        p_waddr     = r_reg;
        p_wdata     = pi_reg;
        out_load    = 1'b0;
        o_status    = STAT_OK;
        o_row       = '0;
        o_col       = '0;
        o_value     = '0;
        o_pointer   = '0;

        case (state_reg)
            S_IDLE:
            begin
                b_addr = item.read_index[ENTRY_AW-1:0];
                if (item_valid && out_free)
                begin
                    item_pop = 1'b1;
                    case (item.op)
                        OP_LOAD:
                        begin
                            out_load = 1'b1;
                            if (count_reg == CNT_W'(MAX_ENTRIES))
                            begin
                                o_status = STAT_FULL;
                            end
                            else if (bad_coord)
                            begin
                                o_status = STAT_RANGE;
                            end
                            else
                            begin
                                a_we        = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                                sorted_next = 1'b0;
                            end
                        end
                        OP_FINISH:
                        begin
                            i_next  = '0;
                            pi_next = '0;
                            r_next  = '0;
                            if (count_reg == '0)
                            begin
                                state_next = S_PT_ISSUE;
                            end
                            else
                            begin
                                state_next = S_RK_ISSUE;
                            end
                        end
                        OP_READ_ENT:
                        begin
                            if (!sorted_reg)
                            begin
                                out_load = 1'b1;
                                o_status = STAT_NOT_SORTED;
                            end
                            else if (CNT_W'(item.read_index) >= count_reg)
                            begin
                                out_load = 1'b1;
                                o_status = STAT_BAD_INDEX;
                            end
                            else
                            begin
                                state_next = S_RD_ENT;
                            end
                        end
                        OP_READ_PTR:
                        begin
                            if (!sorted_reg)
                            begin
                                out_load = 1'b1;
                                o_status = STAT_NOT_SORTED;
                            end
                            else if (item.read_index > rows_reg)
                            begin
                                out_load = 1'b1;
                                o_status = STAT_BAD_INDEX;
                            end
                            else
                            begin
                                state_next = S_RD_PTR;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RK_ISSUE:
            begin
                a_addr     = i_reg;
                state_next = S_RK_KEY;
            end
            S_RK_KEY:
            begin
                key_load   = 1'b1;
                a_addr     = '0;
                dj_next    = '0;
                rank_next  = '0;
                state_next = S_RK_SCAN;
            end
            S_RK_SCAN:
            begin
                rank_next = rank_reg + ENTRY_AW'(hit);
                if (CNT_W'(dj_reg) + CNT_W'(1) == count_reg)
                begin
                    state_next = S_RK_WRITE;
                end
                else
                begin
                    a_addr  = dj_reg + ENTRY_AW'(1);
                    dj_next = dj_reg + ENTRY_AW'(1);
                end
            end
            S_RK_WRITE:
            begin
                b_we = 1'b1;
                if (CNT_W'(i_reg) + CNT_W'(1) == count_reg)
                begin
                    state_next = S_PT_ISSUE;
                end
                else
                begin
                    i_next     = i_reg + ENTRY_AW'(1);
                    state_next = S_RK_ISSUE;
                end
            end
            S_PT_ISSUE:
            begin
                b_addr     = pi_reg[ENTRY_AW-1:0];
                state_next = S_PT_CMP;
            end
            S_PT_CMP:
            begin
                if (DIM_W'(r_reg) == rows_reg)
                begin
                    p_we        = 1'b1;
                    p_wdata     = count_reg;
                    sorted_next = 1'b1;
                    out_load    = 1'b1;
                    state_next  = S_IDLE;
                end
                else if ((pi_reg < count_reg) && (PTR_AW'(b_rd_row) < r_reg))
                begin
                    pi_next    = pi_reg + CNT_W'(1);
                    state_next = S_PT_ISSUE;
                end
                else
                begin
                    p_we   = 1'b1;
                    r_next = r_reg + PTR_AW'(1);
                end
            end
            S_RD_ENT:
            begin
                out_load = 1'b1;
                o_row    = b_rd_row;
                o_col    = b_rd_col;
                o_value  = b_rd_val;
                state_next = S_IDLE;
            end
            S_RD_PTR:
            begin
                out_load   = 1'b1;
                o_pointer  = p_rd;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            sorted_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sorted_reg    <= 1'b0;
            rows_reg      <= DIM_W'(MAX_DIM);
            cols_reg      <= DIM_W'(MAX_DIM);
            i_reg         <= '0;
            dj_reg        <= '0;
            rank_reg      <= '0;
            pi_reg        <= '0;
            r_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sorted_reg <= sorted_next;
            i_reg      <= i_next;
            dj_reg     <= dj_next;
            rank_reg   <= rank_next;
            pi_reg     <= pi_next;
            r_reg      <= r_next;
            if (cfg_write)
            begin
                if (cfg_index == CFG_NUM_ROWS)
                begin
                    rows_reg <= cfg_eff;
                end
                else
                begin
                    cols_reg <= cfg_eff;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_load)
        begin
            key_row_reg <= a_rd_row;
            key_col_reg <= a_rd_col;
            key_val_reg <= a_rd_val;
        end
        if (out_load)
        begin
            status_reg      <= o_status;
            out_row_reg     <= o_row;
            out_col_reg     <= o_col;
            out_value_reg   <= o_value;
            out_pointer_reg <= o_pointer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_row[count_reg[ENTRY_AW-1:0]] <= COORD_W'(item.row_number - DIM_W'(1));
            a_col[count_reg[ENTRY_AW-1:0]] <= COORD_W'(item.col_number - DIM_W'(1));
            a_val[count_reg[ENTRY_AW-1:0]] <= item.value_bits;
        end
        a_rd_row <= a_row[a_addr];
        a_rd_col <= a_col[a_addr];
        a_rd_val <= a_val[a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_row[rank_reg] <= key_row_reg;
            b_col[rank_reg] <= key_col_reg;
            b_val[rank_reg] <= key_val_reg;
        end
        b_rd_row <= b_row[b_addr];
        b_rd_col <= b_col[b_addr];
        b_rd_val <= b_val[b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            p_mem[p_waddr] <= p_wdata;
        end
        p_rd <= p_mem[item.read_index];
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign out_value   = out_value_reg;
    assign out_pointer = out_pointer_reg;
    assign entry_total = count_reg;

endmodule

`default_nettype wire

// ===== hdl/coo_to_csr_converter.sv =====
// ----------------------------------------------------------------------------
// coo_to_csr_converter
// Loads sparse triplets, sorts them by row then column on finish, builds
// CSR row pointers and serves reads of entries and pointers.
// ----------------------------------------------------------------------------
//   channel   handshake             payload
//   request   in_valid / in_stall   req_type row_number col_number value_bits
//                                   read_index
//   result    out_valid / out_stall status out_row out_col out_value
//                                   out_pointer entry_total
//   config    cfg_write             cfg_index cfg_data
//
// A load or a flagged request is answered straight from the idle state; a
// good read first passes through a registered memory read. Finish ranks
// each entry by a scan over the one read port of the load store, then runs
// the pointer sweep. The two-slot request queue keeps accepting while it
// has a free slot, also while the back end works or a result is stalled.
// Reset clears only control state; the stores need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module coo_to_csr_converter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic                          cfg_index,
    input  wire logic [c2c_pkg::DIM_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [c2c_pkg::REQ_W-1:0]     req_type,
    input  wire logic [c2c_pkg::DIM_W-1:0]     row_number,
    input  wire logic [c2c_pkg::DIM_W-1:0]     col_number,
    input  wire logic [c2c_pkg::VAL_W-1:0]     value_bits,
    input  wire logic [c2c_pkg::DIM_W-1:0]     read_index,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [c2c_pkg::STAT_W-1:0]         status,
    output logic [c2c_pkg::COORD_W-1:0]        out_row,
    output logic [c2c_pkg::COORD_W-1:0]        out_col,
    output logic [c2c_pkg::VAL_W-1:0]          out_value,
    output logic [c2c_pkg::DIM_W-1:0]          out_pointer,
    output logic [c2c_pkg::DIM_W-1:0]          entry_total
);
    import c2c_pkg::*;

    logic  item_valid;
    item_t item;
    logic  item_pop;

    c2c_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .row_number (row_number),
        .col_number (col_number),
        .value_bits (value_bits),
        .read_index (read_index),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    c2c_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item        (item),
        .item_pop    (item_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .out_pointer (out_pointer),
        .entry_total (entry_total)
    );

endmodule

`default_nettype wire

// ===== hdl/c2c_checker.sv =====
// ----------------------------------------------------------------------------
// c2c_checker
// Port-level checks of the converter, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module c2c_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [c2c_pkg::STAT_W-1:0]    status,
    input  wire logic [c2c_pkg::COORD_W-1:0]   out_row,
    input  wire logic [c2c_pkg::COORD_W-1:0]   out_col,
    input  wire logic [c2c_pkg::VAL_W-1:0]     out_value,
    input  wire logic [c2c_pkg::DIM_W-1:0]     out_pointer,
    input  wire logic [c2c_pkg::DIM_W-1:0]     entry_total
);
    import c2c_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(out_value))
        else $error("stalled result changed");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> out_row == '0 && out_col == '0
            && out_value == '0 && out_pointer == '0)
        else $error("flagged result carries data");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_pointer <= entry_total
            && entry_total <= DIM_W'(MAX_ENTRIES))
        else $error("pointer or count out of bound");

endmodule

bind coo_to_csr_converter c2c_checker u_c2c_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_value   (out_value),
    .out_pointer (out_pointer),
    .entry_total (entry_total)
);

`default_nettype wire
